// ----- src/psaa_pkg.sv -----
// Package: shared types, codes and constants of the point snap and axis align block.
`timescale 1ns / 1ps
package psaa_pkg;

	localparam int COORD_BITS     = 32;
	localparam int MAX_POINTS_DEF = 256;
	localparam int MAX_LINES_DEF  = 256;
	localparam int RADIUS_BITS    = 31;
	localparam int COUNT_BITS     = 9;
	localparam int CFG_IDX_BITS   = 2;
	localparam int SQ_BITS        = 2 * RADIUS_BITS;
	localparam logic [63:0] FAR_LIMIT = 64'h0000_0000_8000_0000;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 31'd65536;
	localparam logic [RADIUS_BITS-1:0] TOL_RESET    = 31'd32768;

	// operation codes
	localparam logic [1:0] OP_WR_POINT = 2'd0;
	localparam logic [1:0] OP_WR_LINE  = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_SNAP_RADIUS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ALIGN_TOL   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POINTS      = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LINES       = 2'd3;

	typedef struct packed {
		logic [1:0]                   op;
		logic [7:0]                   entry_index;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
		logic                         is_snappable;
		logic [7:0]                   start_point;
		logic [7:0]                   stop_point;
	} psaa_in_t;

	typedef struct packed {
		logic                         snapped;
		logic                         aligned_x;
		logic                         aligned_y;
		logic signed [COORD_BITS-1:0] result_x;
		logic signed [COORD_BITS-1:0] result_y;
	} psaa_out_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         flag;
	} psaa_pt_t;

	typedef struct packed {
		logic [7:0] start_pt;
		logic [7:0] stop_pt;
	} psaa_ln_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_SNAP_INIT,
		CMD_SQ_X,
		CMD_SQ_Y,
		CMD_SNAP_CMP,
		CMD_ALIGN_INIT,
		CMD_ALIGN
	} psaa_cmd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_P_CHK,
		S_P_RD,
		S_P_LD,
		S_L_CHK,
		S_L_RD,
		S_L_PRD,
		S_L_LD,
		S_L_SEL,
		S_SQX,
		S_SQY,
		S_CMP,
		S_AL,
		S_RET,
		S_AINIT,
		S_DONE
	} psaa_state_t;

	typedef enum logic [1:0] {
		K_PT,
		K_A,
		K_B,
		K_M
	} psaa_kind_t;

endpackage

// ----- src/point_snap_and_axis_align.sv -----
// Top level: point snap and axis align engine with sequencer and config registers.
`timescale 1ns / 1ps
// A transaction is taken when start is high and busy is low. Point and line writes
// (op 0 and 1) finish in the cycle they are taken and give no result; op 3 is dropped.
// A query (op 2) keeps busy high while a small sequencer walks the tables through
// one shared distance unit: each point passes through check, read, load and return,
// plus square x, square y and compare when snappable; each line is fetched through
// check, line read, point read and load, then each start, stop and midpoint candidate
// passes through select and return, plus square x, square y and compare when that
// candidate is usable. If nothing snaps a second pass over the same tables does the
// per-axis alignment with a single align compare per candidate. The single squarer
// and the registered table reads set the pace. The result is shown for exactly one
// cycle with done high; the receiver cannot stall it, so it must be captured then.
// Tables have no reset: entries must be written before a query reaches them.
// The user must issue config writes only while busy is low; the block itself does
// not enforce it.
module point_snap_and_axis_align import psaa_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_LINES  = MAX_LINES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  psaa_in_t                cmd,
	output logic                    done,
	output psaa_out_t               result,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [RADIUS_BITS-1:0]  cfg_data
);

	localparam int PAW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int LAW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int MAXN = (MAX_POINTS > MAX_LINES) ? MAX_POINTS : MAX_LINES;
	localparam int IW   = $clog2(MAXN + 1);

	// config registers
	logic [RADIUS_BITS-1:0] radius_q, tol_q;
	logic [COUNT_BITS-1:0]  points_q, lines_q;

	psaa_state_t state_q, state_d;
	psaa_kind_t  kind_q;
	logic        align_q;
	logic [IW-1:0] idx_q;
	logic signed [COORD_BITS-1:0] qx_q, qy_q, cx_q, cy_q;
	psaa_pt_t    pa_q, pb_q;
	logic        oka_q, okb_q;

	logic [31:0] np, nl;
	logic        take;
	psaa_cmd_t   ucmd;
	psaa_out_t   ures;

	logic           pt_we, ln_we;
	logic [PAW-1:0] pt_raddr_a, pt_raddr_b;
	logic [LAW-1:0] ln_raddr;
	psaa_pt_t       pt_wdata, pt_rdata_a, pt_rdata_b;
	psaa_ln_t       ln_wdata, ln_rdata;

	logic [COORD_BITS:0] mid_sx, mid_sy;
	logic                cand_ok;

	assign take = start && (state_q == S_IDLE);
	assign np = (32'(points_q) > MAX_POINTS) ? 32'(MAX_POINTS) : 32'(points_q);
	assign nl = (32'(lines_q) > MAX_LINES) ? 32'(MAX_LINES) : 32'(lines_q);

	// midpoint floors toward minus infinity
	assign mid_sx = {pa_q.x[COORD_BITS-1], pa_q.x} + {pb_q.x[COORD_BITS-1], pb_q.x};
	assign mid_sy = {pa_q.y[COORD_BITS-1], pa_q.y} + {pb_q.y[COORD_BITS-1], pb_q.y};

	always_comb begin
		case (kind_q)
			K_A:     cand_ok = oka_q;
			K_B:     cand_ok = okb_q;
			default: cand_ok = oka_q && okb_q;
		endcase
	end

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			tol_q    <= TOL_RESET;
			points_q <= '0;
			lines_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SNAP_RADIUS: radius_q <= cfg_data;
				CFG_ALIGN_TOL:   tol_q    <= cfg_data;
				CFG_POINTS:      points_q <= COUNT_BITS'(cfg_data);
				CFG_LINES:       lines_q  <= COUNT_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (take && cmd.op == OP_QUERY) state_d = S_INIT;
			S_INIT:  state_d = S_P_CHK;
			S_AINIT: state_d = S_P_CHK;
			S_P_CHK: state_d = (32'(idx_q) < np) ? S_P_RD : S_L_CHK;
			S_P_RD:  state_d = S_P_LD;
			S_P_LD: begin
				if (pt_rdata_a.flag) state_d = align_q ? S_AL : S_SQX;
				else state_d = S_RET;
			end
			S_L_CHK: begin
				if (32'(idx_q) < nl) state_d = S_L_RD;
				else if (!align_q && !ures.snapped) state_d = S_AINIT;
				else state_d = S_DONE;
			end
			S_L_RD:  state_d = S_L_PRD;
			S_L_PRD: state_d = S_L_LD;
			S_L_LD:  state_d = S_L_SEL;
			S_L_SEL: begin
				if (cand_ok) state_d = align_q ? S_AL : S_SQX;
				else state_d = S_RET;
			end
			S_SQX:   state_d = S_SQY;
			S_SQY:   state_d = S_CMP;
			S_CMP:   state_d = S_RET;
			S_AL:    state_d = S_RET;
			S_RET: begin
				unique case (kind_q)
					K_PT:    state_d = S_P_CHK;
					K_M:     state_d = S_L_CHK;
					default: state_d = S_L_SEL;
				endcase
			end
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ucmd       = CMD_HOLD;
		pt_raddr_a = PAW'(idx_q);
		pt_raddr_b = PAW'(idx_q);
		ln_raddr   = LAW'(idx_q);
		unique case (state_q)
			S_INIT:  ucmd = CMD_SNAP_INIT;
			S_AINIT: ucmd = CMD_ALIGN_INIT;
			S_L_PRD: begin
				pt_raddr_a = PAW'(ln_rdata.start_pt);
				pt_raddr_b = PAW'(ln_rdata.stop_pt);
			end
			S_SQX:   ucmd = CMD_SQ_X;
			S_SQY:   ucmd = CMD_SQ_Y;
			S_CMP:   ucmd = CMD_SNAP_CMP;
			S_AL:    ucmd = CMD_ALIGN;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_PT;
			align_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_INIT: begin
					idx_q   <= '0;
					align_q <= 1'b0;
					kind_q  <= K_PT;
				end
				S_AINIT: begin
					idx_q   <= '0;
					align_q <= 1'b1;
					kind_q  <= K_PT;
				end
				S_P_CHK: begin
					if (!(32'(idx_q) < np)) idx_q <= '0;
				end
				S_P_RD:  kind_q <= K_PT;
				S_L_LD:  kind_q <= align_q ? K_M : K_A;
				S_RET: begin
					unique case (kind_q)
						K_PT, K_M: idx_q <= idx_q + 1'b1;
						K_A:       kind_q <= K_B;
						default:   kind_q <= K_M;
					endcase
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			qx_q <= cmd.coord_x;
			qy_q <= cmd.coord_y;
		end
		case (state_q)
			S_P_LD: begin
				cx_q <= pt_rdata_a.x;
				cy_q <= pt_rdata_a.y;
			end
			S_L_PRD: begin
				oka_q <= 32'(ln_rdata.start_pt) < MAX_POINTS;
				okb_q <= 32'(ln_rdata.stop_pt) < MAX_POINTS;
			end
			S_L_LD: begin
				pa_q  <= pt_rdata_a;
				pb_q  <= pt_rdata_b;
				oka_q <= oka_q && pt_rdata_a.flag;
				okb_q <= okb_q && pt_rdata_b.flag;
			end
			S_L_SEL: begin
				case (kind_q)
					K_A: begin
						cx_q <= pa_q.x;
						cy_q <= pa_q.y;
					end
					K_B: begin
						cx_q <= pb_q.x;
						cy_q <= pb_q.y;
					end
					default: begin
						cx_q <= mid_sx[COORD_BITS:1];
						cy_q <= mid_sy[COORD_BITS:1];
					end
				endcase
			end
			default: ;
		endcase
	end

	// table writes happen in the accept cycle
	assign pt_we = take && (cmd.op == OP_WR_POINT) && (32'(cmd.entry_index) < MAX_POINTS);
	assign ln_we = take && (cmd.op == OP_WR_LINE) && (32'(cmd.entry_index) < MAX_LINES);
	assign pt_wdata.x    = cmd.coord_x;
	assign pt_wdata.y    = cmd.coord_y;
	assign pt_wdata.flag = cmd.is_snappable;
	assign ln_wdata.start_pt = cmd.start_point;
	assign ln_wdata.stop_pt  = cmd.stop_point;

	psaa_tables #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_LINES (MAX_LINES)
	) u_tables (
		.clk       (clk),
		.pt_we     (pt_we),
		.pt_waddr  (PAW'(cmd.entry_index)),
		.pt_wdata  (pt_wdata),
		.pt_raddr_a(pt_raddr_a),
		.pt_raddr_b(pt_raddr_b),
		.pt_rdata_a(pt_rdata_a),
		.pt_rdata_b(pt_rdata_b),
		.ln_we     (ln_we),
		.ln_waddr  (LAW'(cmd.entry_index)),
		.ln_wdata  (ln_wdata),
		.ln_raddr  (ln_raddr),
		.ln_rdata  (ln_rdata)
	);

	psaa_unit u_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (ucmd),
		.qx    (qx_q),
		.qy    (qy_q),
		.cx    (cx_q),
		.cy    (cy_q),
		.radius(radius_q),
		.tol   (tol_q),
		.res   (ures)
	);

	assign result = ures;

	// checks
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.op != OP_QUERY) |=> !busy)
		else $error("write transaction left the block busy");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(take && cmd.op == OP_QUERY) |=> busy)
		else $error("query did not start the sequencer");

	a_snap_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.snapped) |-> (!result.aligned_x && !result.aligned_y))
		else $error("snapped result also flagged as aligned");

endmodule

// ----- src/psaa_tables.sv -----
// Point and line table memories with registered reads.
`timescale 1ns / 1ps
module psaa_tables import psaa_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_LINES  = MAX_LINES_DEF,
	localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int LAW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1
) (
	input  logic           clk,
	input  logic           pt_we,
	input  logic [PAW-1:0] pt_waddr,
	input  psaa_pt_t       pt_wdata,
	input  logic [PAW-1:0] pt_raddr_a,
	input  logic [PAW-1:0] pt_raddr_b,
	output psaa_pt_t       pt_rdata_a,
	output psaa_pt_t       pt_rdata_b,
	input  logic           ln_we,
	input  logic [LAW-1:0] ln_waddr,
	input  psaa_ln_t       ln_wdata,
	input  logic [LAW-1:0] ln_raddr,
	output psaa_ln_t       ln_rdata
);

	psaa_pt_t pt_mem [MAX_POINTS];
	psaa_ln_t ln_mem [MAX_LINES];

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_waddr] <= pt_wdata;
		end
		pt_rdata_a <= pt_mem[pt_raddr_a];
		pt_rdata_b <= pt_mem[pt_raddr_b];
	end

	always_ff @(posedge clk) begin
		if (ln_we) begin
			ln_mem[ln_waddr] <= ln_wdata;
		end
		ln_rdata <= ln_mem[ln_raddr];
	end

endmodule

// ----- src/psaa_unit.sv -----
// Shared distance unit: abs difference, one squarer, snap and align compares.
`timescale 1ns / 1ps
module psaa_unit import psaa_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  psaa_cmd_t                    cmd,
	input  logic signed [COORD_BITS-1:0] qx,
	input  logic signed [COORD_BITS-1:0] qy,
	input  logic signed [COORD_BITS-1:0] cx,
	input  logic signed [COORD_BITS-1:0] cy,
	input  logic [RADIUS_BITS-1:0]       radius,
	input  logic [RADIUS_BITS-1:0]       tol,
	output psaa_out_t                    res
);

	localparam int DW = COORD_BITS + 1;

	logic signed [DW-1:0]     ex, ey;
	logic [DW-1:0]            dx, dy;
	logic                     far_x, far_y;
	logic [RADIUS_BITS-1:0]   mul_a;
	logic [SQ_BITS-1:0]       mul_p;
	logic [SQ_BITS:0]         sum;
	logic                     snap_hit, hit_x, hit_y;

	logic [SQ_BITS-1:0]       sqx_q, sqy_q, best_q;
	logic                     far_q;
	logic [RADIUS_BITS-1:0]   bestx_q, besty_q;
	logic signed [COORD_BITS-1:0] rx_q, ry_q;
	logic                     snapped_q, ax_q, ay_q;

	assign ex = {qx[COORD_BITS-1], qx} - {cx[COORD_BITS-1], cx};
	assign ey = {qy[COORD_BITS-1], qy} - {cy[COORD_BITS-1], cy};
	assign dx = ex[DW-1] ? (~ex + 1'b1) : ex;
	assign dy = ey[DW-1] ? (~ey + 1'b1) : ey;
	assign far_x = 64'(dx) >= FAR_LIMIT;
	assign far_y = 64'(dy) >= FAR_LIMIT;

	// single squarer, operand picked by the sequencer step
	always_comb begin
		case (cmd)
			CMD_SNAP_INIT: mul_a = radius;
			CMD_SQ_X:      mul_a = RADIUS_BITS'(dx);
			CMD_SQ_Y:      mul_a = RADIUS_BITS'(dy);
			default:       mul_a = '0;
		endcase
	end
	assign mul_p = SQ_BITS'(mul_a) * SQ_BITS'(mul_a);

	assign sum      = (SQ_BITS + 1)'(sqx_q) + (SQ_BITS + 1)'(sqy_q);
	assign snap_hit = !far_q && (sum < (SQ_BITS + 1)'(best_q));
	assign hit_x    = 64'(dx) < 64'(bestx_q);
	assign hit_y    = 64'(dy) < 64'(besty_q);

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_SNAP_INIT: begin
				best_q <= mul_p;
				rx_q   <= qx;
				ry_q   <= qy;
			end
			CMD_SQ_X: sqx_q <= mul_p;
			CMD_SQ_Y: begin
				sqy_q <= mul_p;
				far_q <= far_x || far_y;
			end
			CMD_SNAP_CMP: begin
				if (snap_hit) begin
					best_q <= SQ_BITS'(sum);
					rx_q   <= cx;
					ry_q   <= cy;
				end
			end
			CMD_ALIGN_INIT: begin
				bestx_q <= tol;
				besty_q <= tol;
				rx_q    <= qx;
				ry_q    <= qy;
			end
			CMD_ALIGN: begin
				if (hit_x) begin
					bestx_q <= RADIUS_BITS'(dx);
					rx_q    <= cx;
				end
				if (hit_y) begin
					besty_q <= RADIUS_BITS'(dy);
					ry_q    <= cy;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snapped_q <= 1'b0;
			ax_q      <= 1'b0;
			ay_q      <= 1'b0;
		end else begin
			case (cmd)
				CMD_SNAP_INIT, CMD_ALIGN_INIT: begin
					snapped_q <= 1'b0;
					ax_q      <= 1'b0;
					ay_q      <= 1'b0;
				end
				CMD_SNAP_CMP: if (snap_hit) snapped_q <= 1'b1;
				CMD_ALIGN: begin
					if (hit_x) ax_q <= 1'b1;
					if (hit_y) ay_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign res.snapped   = snapped_q;
	assign res.aligned_x = ax_q;
	assign res.aligned_y = ay_q;
	assign res.result_x  = rx_q;
	assign res.result_y  = ry_q;

endmodule

// ----- tb/psaa_checker.sv -----
// Checker: watches the command, result and config channels, predicts each query and compares.
`timescale 1ns / 1ps
module psaa_checker import psaa_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  psaa_in_t                cmd,
	input  logic                    done,
	input  psaa_out_t               result,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [RADIUS_BITS-1:0]  cfg_data,
	output int                      fails,
	output int                      pending
);

	localparam int NPT = 256;
	localparam int NLN = 256;

	logic signed [COORD_BITS-1:0] px [NPT];
	logic signed [COORD_BITS-1:0] py [NPT];
	logic                         pf [NPT];
	logic [7:0]                   ln_a [NLN];
	logic [7:0]                   ln_b [NLN];

	logic [RADIUS_BITS-1:0] radius_r;
	logic [RADIUS_BITS-1:0] tol_r;
	logic [COUNT_BITS-1:0]  npts_r;
	logic [COUNT_BITS-1:0]  nlns_r;

	psaa_out_t query_q[$];

	function automatic logic [63:0] gap(logic signed [COORD_BITS-1:0] a,
			logic signed [COORD_BITS-1:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return (d < 0) ? 64'(-d) : 64'(d);
	endfunction

	// floor of the average: 33-bit sum, drop the low bit
	function automatic logic signed [COORD_BITS-1:0] mid(logic signed [COORD_BITS-1:0] a,
			logic signed [COORD_BITS-1:0] b);
		logic signed [COORD_BITS:0] s;
		s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
		return s[COORD_BITS:1];
	endfunction

	function automatic void snap_cand(input logic signed [COORD_BITS-1:0] qx, qy, cx, cy,
			inout logic [63:0] best, inout logic signed [COORD_BITS-1:0] bx, by,
			inout bit hit);
		logic [63:0] dx, dy, d2;
		dx = gap(qx, cx);
		dy = gap(qy, cy);
		if (dx >= FAR_LIMIT || dy >= FAR_LIMIT) return;
		d2 = dx * dx + dy * dy;
		if (d2 < best) begin
			best = d2;
			bx = cx;
			by = cy;
			hit = 1'b1;
		end
	endfunction

	function automatic void align_cand(input logic signed [COORD_BITS-1:0] q, c,
			inout logic [63:0] best, inout logic signed [COORD_BITS-1:0] r,
			inout bit hit);
		logic [63:0] d;
		d = gap(q, c);
		if (d < best) begin
			best = d;
			r = c;
			hit = 1'b1;
		end
	endfunction

	function automatic psaa_out_t snap_align(logic signed [COORD_BITS-1:0] qx, qy);
		psaa_out_t o;
		logic [63:0] best, bestx, besty;
		logic signed [COORD_BITS-1:0] rx, ry;
		bit sn, ax, ay, oka, okb;
		int np, nl;
		np = (npts_r > NPT) ? NPT : int'(npts_r);
		nl = (nlns_r > NLN) ? NLN : int'(nlns_r);
		rx = qx;
		ry = qy;
		sn = 0;
		ax = 0;
		ay = 0;
		best = 64'(radius_r) * 64'(radius_r);
		for (int i = 0; i < np; i++)
			if (pf[i]) snap_cand(qx, qy, px[i], py[i], best, rx, ry, sn);
		for (int i = 0; i < nl; i++) begin
			oka = pf[ln_a[i]];
			okb = pf[ln_b[i]];
			if (oka) snap_cand(qx, qy, px[ln_a[i]], py[ln_a[i]], best, rx, ry, sn);
			if (okb) snap_cand(qx, qy, px[ln_b[i]], py[ln_b[i]], best, rx, ry, sn);
			if (oka && okb)
				snap_cand(qx, qy, mid(px[ln_a[i]], px[ln_b[i]]),
					mid(py[ln_a[i]], py[ln_b[i]]), best, rx, ry, sn);
		end
		if (!sn) begin
			rx = qx;
			ry = qy;
			bestx = 64'(tol_r);
			besty = 64'(tol_r);
			for (int i = 0; i < np; i++)
				if (pf[i]) begin
					align_cand(qx, px[i], bestx, rx, ax);
					align_cand(qy, py[i], besty, ry, ay);
				end
			for (int i = 0; i < nl; i++)
				if (pf[ln_a[i]] && pf[ln_b[i]]) begin
					align_cand(qx, mid(px[ln_a[i]], px[ln_b[i]]), bestx, rx, ax);
					align_cand(qy, mid(py[ln_a[i]], py[ln_b[i]]), besty, ry, ay);
				end
		end
		o.snapped   = sn;
		o.aligned_x = ax;
		o.aligned_y = ay;
		o.result_x  = rx;
		o.result_y  = ry;
		return o;
	endfunction

	task automatic field_diff(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		psaa_out_t exp_r;
		if (!arst_n) begin
			radius_r = RADIUS_RESET;
			tol_r    = TOL_RESET;
			npts_r   = '0;
			nlns_r   = '0;
			fails    = 0;
			query_q.delete();
			pending  <= 0;
		end else begin
			if (done) begin
				if (query_q.size() == 0) begin
					$display("%0t unexpected result %h", $time, result);
					fails++;
				end else begin
					exp_r = query_q.pop_front();
					field_diff("snapped", exp_r.snapped, result.snapped);
					field_diff("aligned_x", exp_r.aligned_x, result.aligned_x);
					field_diff("aligned_y", exp_r.aligned_y, result.aligned_y);
					field_diff("result_x", exp_r.result_x, result.result_x);
					field_diff("result_y", exp_r.result_y, result.result_y);
				end
			end
			if (cfg_we)
				case (cfg_index)
					CFG_SNAP_RADIUS: radius_r = cfg_data;
					CFG_ALIGN_TOL:   tol_r    = cfg_data;
					CFG_POINTS:      npts_r   = cfg_data[COUNT_BITS-1:0];
					CFG_LINES:       nlns_r   = cfg_data[COUNT_BITS-1:0];
				endcase
			if (start && !busy)
				case (cmd.op)
					OP_WR_POINT: begin
						px[cmd.entry_index] = cmd.coord_x;
						py[cmd.entry_index] = cmd.coord_y;
						pf[cmd.entry_index] = cmd.is_snappable;
					end
					OP_WR_LINE: begin
						ln_a[cmd.entry_index] = cmd.start_point;
						ln_b[cmd.entry_index] = cmd.stop_point;
					end
					OP_QUERY: query_q.push_back(snap_align(cmd.coord_x, cmd.coord_y));
					default: ;
				endcase
			pending <= query_q.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, stimulus for the snap and align block, and the verdict.
`timescale 1ns / 1ps
module tb_top;
	import psaa_pkg::*;

	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam int     MM          = 65536;	// one millimetre in Q15.16

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	psaa_in_t                cmd = '0;
	logic                    done;
	psaa_out_t               result;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [RADIUS_BITS-1:0]  cfg_data = '0;
	int                      fails;
	int                      pending;
	longint                  cycles = 0;

	// stimulus-side copy of point coordinates, only used to aim queries
	logic signed [COORD_BITS-1:0] aim_x [256];
	logic signed [COORD_BITS-1:0] aim_y [256];
	bit                           gaps_on = 1'b1;

	always #4 clk = ~clk;

	point_snap_and_axis_align dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	psaa_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fails(fails), .pending(pending)
	);

	// watchdog: a hung sequencer ends the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Present one transaction and hold it until it is taken. start stays high on
	// return, so a back-to-back caller just overwrites cmd in the same step.
	task automatic issue(psaa_in_t t);
		if (gaps_on && $urandom_range(0, 99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= t;
		if (t.op == OP_WR_POINT) begin
			aim_x[t.entry_index] = t.coord_x;
			aim_y[t.entry_index] = t.coord_y;
		end
		do @(posedge clk); while (busy);
	endtask

	// drain every outstanding query before touching a register
	task automatic quiesce();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_wr(logic [CFG_IDX_BITS-1:0] idx, logic [RADIUS_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all(logic [RADIUS_BITS-1:0] r, logic [RADIUS_BITS-1:0] tol,
			int np, int nl);
		quiesce();
		reg_wr(CFG_SNAP_RADIUS, r);
		reg_wr(CFG_ALIGN_TOL, tol);
		reg_wr(CFG_POINTS, RADIUS_BITS'(np));
		reg_wr(CFG_LINES, RADIUS_BITS'(nl));
	endtask

	function automatic psaa_in_t mk(logic [1:0] op, int idx, logic [31:0] x, logic [31:0] y,
			bit f, int a, int b);
		psaa_in_t t;
		t.op           = op;
		t.entry_index  = 8'(idx);
		t.coord_x      = x;
		t.coord_y      = y;
		t.is_snappable = f;
		t.start_point  = 8'(a);
		t.stop_point   = 8'(b);
		return t;
	endfunction

	// coordinates clustered within a few millimetres of the origin
	function automatic logic [31:0] near0();
		return 32'($urandom_range(0, 8 * MM)) - 32'(4 * MM);
	endfunction

	function automatic logic [31:0] jitter(logic [31:0] c);
		return c + 32'($urandom_range(0, 4 * MM)) - 32'(2 * MM);
	endfunction

	function automatic logic [RADIUS_BITS-1:0] pick_thr();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return 31'h7FFF_FFFF;
			2:       return RADIUS_BITS'($urandom_range(1, 3 * MM));
			3:       return RADIUS_BITS'($urandom_range(0, MM));
			4:       return RADIUS_BITS'($urandom);
			default: return RADIUS_BITS'(MM);
		endcase
	endfunction

	initial begin
		int k, np, nl;
		logic [31:0] qx, qy;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty tables at reset config: the query comes back unchanged;
		// an unused op code is dropped with no result
		issue(mk(OP_QUERY, 0, 32'h1234_5678, 32'hFEDC_BA98, 0, 0, 0));
		issue(mk(2'd3, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 255, 255));

		// fill every slot so no scan ever reads an unwritten entry
		for (int i = 0; i < 256; i++)
			issue(mk(OP_WR_POINT, i, near0(), near0(), $urandom_range(0, 3) != 0, 0, 0));
		for (int i = 0; i < 256; i++)
			issue(mk(OP_WR_LINE, i, 0, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255)));

		// extreme coordinates: midpoint of the two corners, far-limit rejection
		issue(mk(OP_WR_POINT, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0));
		issue(mk(OP_WR_POINT, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0));
		issue(mk(OP_WR_POINT, 2, 32'h8000_0001, 32'h8000_0001, 1, 0, 0));
		issue(mk(OP_WR_POINT, 3, 32'h0000_0010, 32'hFFFF_FFF0, 0, 0, 0));
		issue(mk(OP_WR_LINE, 0, 0, 0, 0, 0, 1));
		issue(mk(OP_WR_LINE, 1, 0, 0, 0, 2, 3));
		issue(mk(OP_WR_LINE, 2, 0, 0, 0, 2, 2));
		set_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 4, 3);
		issue(mk(OP_QUERY, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0));
		issue(mk(OP_QUERY, 0, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 0));
		issue(mk(OP_QUERY, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
		// zero thresholds: nothing snaps or aligns, even on an exact hit
		set_all('0, '0, 4, 3);
		issue(mk(OP_QUERY, 0, 32'h8000_0001, 32'h8000_0001, 0, 0, 0));
		// tiny radius: only the exact hit snaps; counts past the table saturate
		set_all(31'd1, 31'd2, 511, 511);
		issue(mk(OP_QUERY, 0, 32'h8000_0001, 32'h8000_0001, 0, 0, 0));
		issue(mk(OP_QUERY, 0, 32'h0000_0011, 32'h1000_0000, 0, 0, 0));
		// restore the cluster near the origin for the random part
		for (int i = 0; i < 4; i++)
			issue(mk(OP_WR_POINT, i, near0(), near0(), 1, 0, 0));

		for (int ph = 0; ph < 14; ph++) begin
			gaps_on = !(ph >= 5 && ph < 10);
			if (ph == 2 || ph == 8) begin
				np = 256;
				nl = 256;
			end else if (ph == 11) begin
				np = 511;
				nl = 300;
			end else begin
				np = $urandom_range(0, 32);
				nl = $urandom_range(0, 32);
			end
			set_all(pick_thr(), pick_thr(), np, nl);
			for (int n = 0; n < 4; n++) begin
				k = $urandom_range(0, 99);
				if (k < 55) begin
					// aim at a candidate so snapping and alignment both get exercised
					k  = $urandom_range(0, 31);
					qx = jitter(aim_x[k]);
					qy = ($urandom_range(0, 3) == 0) ? near0() : jitter(aim_y[k]);
					if ($urandom_range(0, 19) == 0) qx = $urandom;
					issue(mk(OP_QUERY, $urandom_range(0, 255), qx, qy, $urandom_range(0, 1),
						$urandom_range(0, 255), $urandom_range(0, 255)));
				end else if (k < 75) begin
					issue(mk(OP_WR_POINT, $urandom_range(0, 31), near0(), near0(),
						$urandom_range(0, 3) != 0, $urandom_range(0, 255),
						$urandom_range(0, 255)));
				end else if (k < 92) begin
					issue(mk(OP_WR_LINE, $urandom_range(0, 31), $urandom, $urandom,
						$urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 255)));
				end else begin
					issue(mk(2'd3, $urandom_range(0, 255), $urandom, $urandom,
						$urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 255)));
				end
			end
		end

		quiesce();
		repeat (50) @(posedge clk);
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
